// ----- rtl/hndf_pkg.sv -----
// Shared types, constants and helper functions for the hash near-duplicate filter.
// Used by the top level and the front and back ends; depends on nothing.
`timescale 1ns / 1ps

package hndf_pkg;

  localparam int MAX_TILES = 1024;
  localparam int HASH_BITS = 64;
  localparam int HASH_LVLS = $clog2(HASH_BITS);
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int LANES     = 4;
  localparam int LANE_W    = $clog2(LANES);
  localparam int ROWS      = MAX_TILES / LANES;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int ROWCNT_W  = ROW_W + 1;
  localparam int PCNT_W    = $clog2(HASH_BITS + 1);
  localparam int DIST_W    = 7;
  localparam logic [DIST_W-1:0] DIST_RESET = 7'd4;

  // One classified transaction as it travels from the front to the back.
  typedef struct packed {
    logic [HASH_BITS-1:0] hash;
    logic                 empty;
    logic                 last;
    logic [IDX_W-1:0]     idx;
    logic [CNT_W-1:0]     cmp_count;
    logic                 store;
    logic                 full;
  } item_t;

  // Population count as a balanced adder tree, one level per loop pass.
  function automatic logic [PCNT_W-1:0] popcount(input logic [HASH_BITS-1:0] v);
    logic [PCNT_W-1:0] acc [HASH_BITS];
    for (int i = 0; i < HASH_BITS; i++) begin
      acc[i] = PCNT_W'(v[i]);
    end
    for (int lvl = 0; lvl < HASH_LVLS; lvl++) begin
      for (int i = 0; i < HASH_BITS / 2; i++) begin
        if (i < (HASH_BITS >> (lvl + 1))) begin
          acc[i] = acc[2*i] + acc[2*i+1];
        end
      end
    end
    return acc[0];
  endfunction

endpackage

// ----- rtl/hash_near_duplicate_filter.sv -----
// Top level of the hash near-duplicate filter: configuration register and the
// front and back ends. Depends on hndf_pkg, hndf_front and hndf_back.
`timescale 1ns / 1ps

// Usage
// A transaction is taken at a rising edge with start high and busy low; it
// carries tile_hash, is_empty and last_of_set. A two-entry queue sits between
// the front end, which numbers each item and picks its store slot, and the
// back end, which compares the hash with the stored hashes of the set.
// Each transaction gives one result, shown for exactly one cycle with done
// high: tile_index, remove, is_duplicate, table_full and set_done.
// The back end reads four stored hashes per cycle from four RAM lanes and
// compares each item with every hash stored before it in the set, up to a
// full store of 1024; an empty item compares with none. It takes the next item
// from the queue only once it is through with the last, so that scan loop sets
// the sustained rate. The receiver cannot stall: results are delivered as they
// finish. max_distance is written through cfg_we and cfg_wdata only while the
// block is idle; the user is bound to this, as the block does not enforce it.
// Synchronous reset sets max_distance to 4 and empties the queue, the item
// counter and the stored count; the RAM needs no clearing, since only entries
// below the stored count are ever compared.
module hash_near_duplicate_filter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [hndf_pkg::HASH_BITS-1:0] tile_hash,
  input  logic                           is_empty,
  input  logic                           last_of_set,
  input  logic                           cfg_we,
  input  logic [hndf_pkg::DIST_W-1:0]    cfg_wdata,
  output logic                           done,
  output logic [hndf_pkg::IDX_W-1:0]     tile_index,
  output logic                           remove,
  output logic                           is_duplicate,
  output logic                           table_full,
  output logic                           set_done
);

  logic [hndf_pkg::DIST_W-1:0] max_distance;
  logic                        q_valid;
  logic                        q_pop;
  hndf_pkg::item_t             q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= hndf_pkg::DIST_RESET;
    end else if (cfg_we) begin
      max_distance <= cfg_wdata;
    end
  end

  hndf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .hash_in (tile_hash),
    .empty_in(is_empty),
    .last_in (last_of_set),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  hndf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .max_distance(max_distance),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .done        (done),
    .tile_index  (tile_index),
    .remove      (remove),
    .is_duplicate(is_duplicate),
    .table_full  (table_full),
    .set_done    (set_done)
  );

endmodule

// ----- rtl/hndf_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module hndf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/hndf_front.sv -----
// Front end: accepts transactions, assigns index and store slot, and queues them.
// Depends on hndf_pkg.
`timescale 1ns / 1ps

module hndf_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [hndf_pkg::HASH_BITS-1:0] hash_in,
  input  logic                           empty_in,
  input  logic                           last_in,
  output logic                           q_valid,
  output hndf_pkg::item_t                q_head,
  input  logic                           q_pop
);

  logic [hndf_pkg::CNT_W-1:0] stored_count;
  logic [hndf_pkg::IDX_W-1:0] item_counter;
  hndf_pkg::item_t            q_mem [2];
  logic                       wr_ptr;
  logic                       rd_ptr;
  logic [1:0]                 q_cnt;
  logic                       push;
  hndf_pkg::item_t            cls;

  assign busy    = (q_cnt == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (q_cnt != 2'd0);
  assign q_head  = q_mem[rd_ptr];

  always_comb begin
    cls.hash      = hash_in;
    cls.empty     = empty_in;
    cls.last      = last_in;
    cls.idx       = item_counter;
    cls.cmp_count = empty_in ? '0 : stored_count;
    cls.store     = !empty_in && (stored_count < hndf_pkg::CNT_W'(hndf_pkg::MAX_TILES));
    cls.full      = !empty_in && (stored_count >= hndf_pkg::CNT_W'(hndf_pkg::MAX_TILES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      item_counter <= '0;
      wr_ptr       <= 1'b0;
      rd_ptr       <= 1'b0;
      q_cnt        <= 2'd0;
    end else begin
      if (push) begin
        q_mem[wr_ptr] <= cls;
        wr_ptr        <= !wr_ptr;
        if (last_in) begin
          stored_count <= '0;
          item_counter <= '0;
        end else begin
          if (cls.store) begin
            stored_count <= stored_count + hndf_pkg::CNT_W'(1);
          end
          if (item_counter < hndf_pkg::IDX_W'(hndf_pkg::MAX_TILES - 1)) begin
            item_counter <= item_counter + hndf_pkg::IDX_W'(1);
          end
        end
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !q_pop) begin
        q_cnt <= q_cnt + 2'd1;
      end else if (!push && q_pop) begin
        q_cnt <= q_cnt - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/hndf_back.sv -----
// Back end: scans the hash store four entries a cycle, stores the new hash and
// emits the result strobe. Depends on hndf_pkg and hndf_ram.
`timescale 1ns / 1ps

module hndf_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [hndf_pkg::DIST_W-1:0] max_distance,
  input  logic                        q_valid,
  input  hndf_pkg::item_t             q_head,
  output logic                        q_pop,
  output logic                        done,
  output logic [hndf_pkg::IDX_W-1:0]  tile_index,
  output logic                        remove,
  output logic                        is_duplicate,
  output logic                        table_full,
  output logic                        set_done
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]                        state;
  hndf_pkg::item_t                   cur;
  logic [hndf_pkg::ROWCNT_W-1:0]     row;
  logic [hndf_pkg::ROWCNT_W-1:0]     rows_total;
  logic [hndf_pkg::CNT_W-1:0]        cmp_round;
  logic                              issue;
  logic                              finish;
  logic                              dup;
  logic                              p1_v;
  logic [hndf_pkg::ROW_W-1:0]        p1_row;
  logic                              p2_v;
  logic [hndf_pkg::LANES-1:0]        p2_mask;
  logic [hndf_pkg::PCNT_W-1:0]       p2_cnt [hndf_pkg::LANES];
  logic [hndf_pkg::HASH_BITS-1:0]    rd_data [hndf_pkg::LANES];
  logic [hndf_pkg::LANES-1:0]        hit;

  // Rows that hold at least one entry to compare against.
  assign cmp_round  = cur.cmp_count + hndf_pkg::CNT_W'(hndf_pkg::LANES - 1);
  assign rows_total = cmp_round[hndf_pkg::CNT_W-1:hndf_pkg::LANE_W];
  assign issue      = (state == S_SCAN) && (row < rows_total);
  assign finish     = (state == S_DRAIN) && !p1_v && !p2_v;
  assign q_pop      = (state == S_IDLE) && q_valid;

  for (genvar l = 0; l < hndf_pkg::LANES; l++) begin : g_lane
    hndf_ram #(
      .WIDTH(hndf_pkg::HASH_BITS),
      .DEPTH(hndf_pkg::ROWS)
    ) u_ram (
      .clk  (clk),
      .we   (finish && cur.store &&
             (cur.cmp_count[hndf_pkg::LANE_W-1:0] == hndf_pkg::LANE_W'(l))),
      .waddr(cur.cmp_count[hndf_pkg::LANE_W +: hndf_pkg::ROW_W]),
      .wdata(cur.hash),
      .re   (issue),
      .raddr(row[hndf_pkg::ROW_W-1:0]),
      .rdata(rd_data[l])
    );

    assign hit[l] = p2_mask[l] && (p2_cnt[l] <= hndf_pkg::PCNT_W'(max_distance));

    always_ff @(posedge clk) begin
      p2_cnt[l]  <= hndf_pkg::popcount(rd_data[l] ^ cur.hash);
      p2_mask[l] <= (hndf_pkg::CNT_W'({p1_row, hndf_pkg::LANE_W'(l)}) < cur.cmp_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      p1_v  <= 1'b0;
      p2_v  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= finish;
      p1_v <= issue;
      p2_v <= p1_v;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_head;
            row   <= '0;
            dup   <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            row <= row + hndf_pkg::ROWCNT_W'(1);
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (finish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (p2_v && (hit != '0)) begin
        dup <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_row <= row[hndf_pkg::ROW_W-1:0];
    if (finish) begin
      tile_index   <= cur.idx;
      remove       <= cur.empty || dup;
      is_duplicate <= dup;
      table_full   <= cur.full;
      set_done     <= cur.last;
    end
  end

endmodule
